// ===== rtl/core/rkv_pkg.sv =====
// ----------------------------------------------------------------------------
// rkv_pkg: shared types and constants for the refcounted key/value table
// Action and status codes, sequencer states and the scan flag bundle.
// ----------------------------------------------------------------------------
package rkv_pkg;

    localparam int KEY_W      = 16;
    localparam int VALUE_W    = 64;
    localparam int TEXT_LO_W  = 64;
    localparam int TEXT_HI_W  = 56;
    localparam int TEXT_W     = TEXT_LO_W + TEXT_HI_W;
    localparam int TEXT_BYTES = 15;
    localparam int DATA_W     = VALUE_W + TEXT_W;

    localparam logic [1:0] ACTION_ADD = 2'd0;
    localparam logic [1:0] ACTION_DEL = 2'd1;
    localparam logic [1:0] ACTION_LOG = 2'd2;
    localparam logic [1:0] ACTION_GET = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_GET
    } state_t;

    // result of a key scan: live match seen, free slot seen
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

endpackage

// ===== rtl/core/rkv_ram.sv =====
// ----------------------------------------------------------------------------
// rkv_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/rkv_scan.sv =====
// ----------------------------------------------------------------------------
// rkv_scan: key/count compare unit
// Checks one slot per cycle, keeps the first live match and first free slot.
// ----------------------------------------------------------------------------
module rkv_scan #(
    parameter int ENTRIES    = 128,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 8,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   chk_vld,
    input  logic [IDX_W-1:0]       chk_idx,
    input  logic [KEY_BITS-1:0]    rd_key,
    input  logic [COUNT_BITS-1:0]  rd_count,
    input  logic [KEY_BITS-1:0]    req_key,
    output rkv_pkg::scan_flags_t   flags,
    output logic [IDX_W-1:0]       hit_idx,
    output logic [COUNT_BITS-1:0]  hit_count,
    output logic [IDX_W-1:0]       free_idx
);

    rkv_pkg::scan_flags_t  flags_reg, flags_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_count_reg, hit_count_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  live;

    assign live = (rd_count != '0);

    always_comb
    begin
        flags_next     = flags_reg;
        hit_idx_next   = hit_idx_reg;
        hit_count_next = hit_count_reg;
        free_idx_next  = free_idx_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (chk_vld)
        begin
            if (live && (rd_key == req_key) && !flags_reg.hit)
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = chk_idx;
                hit_count_next = rd_count;
            end
            if (!live && !flags_reg.free)
            begin
                flags_next.free = 1'b1;
                free_idx_next   = chk_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        free_idx_reg  <= free_idx_next;
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_count = hit_count_reg;
    assign free_idx  = free_idx_reg;

endmodule

// ===== rtl/core/refcounted_key_value_table.sv =====
// Transactions are handled one at a time: the next is taken once the result is registered,
//   and a stalled result register holds the table in its action step. The scan of the
//   key RAM checks one slot per cycle.
// Reset: asynchronous, active low. After reset a clearing pass writes every slot of
//   both RAMs to zero with in_stall high; config writes still taken.
// ----------------------------------------------------------------------------
// refcounted_key_value_table: reference-counted associative table
// Keyed slots with a use count, a 64-bit value and a 15-byte text. Each
// transaction scans all slots through one compare unit, then acts on the
// matching or first free slot: add, delete, log or get.
// ----------------------------------------------------------------------------
module refcounted_key_value_table #(
    parameter int ENTRIES    = 128,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [rkv_pkg::KEY_W-1:0]     key,
    input  logic [rkv_pkg::VALUE_W-1:0]   value_in,
    input  logic [rkv_pkg::TEXT_LO_W-1:0] text_low_in,
    input  logic [rkv_pkg::TEXT_HI_W-1:0] text_high_in,
    // response channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [rkv_pkg::VALUE_W-1:0]   value_out,
    output logic [rkv_pkg::TEXT_LO_W-1:0] text_low_out,
    output logic [rkv_pkg::TEXT_HI_W-1:0] text_high_out
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KC_W  = KEY_BITS + COUNT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Zero every text byte after the first zero byte. Prefix chain of
    // one-bit flags over the 15 bytes.
    function automatic logic [rkv_pkg::TEXT_W-1:0] term_text(
        input logic [rkv_pkg::TEXT_W-1:0] t
    );
        logic [rkv_pkg::TEXT_W-1:0] r;
        logic                       ended;
        r     = t;
        ended = 1'b0;
        for (int b = 0; b < rkv_pkg::TEXT_BYTES; b++)
        begin
            if (ended)
            begin
                r[b*8 +: 8] = 8'h00;
            end
            else if (t[b*8 +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    rkv_pkg::state_t state_reg, state_next;

    logic                   logging_enabled_reg, logging_enabled_next;

    logic [IDX_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;

    // latched request
    logic [1:0]                    req_action_reg, req_action_next;
    logic [KEY_BITS-1:0]           req_key_reg, req_key_next;
    logic [rkv_pkg::VALUE_W-1:0]   req_value_reg, req_value_next;
    logic [rkv_pkg::TEXT_W-1:0]    req_text_reg, req_text_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [rkv_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [rkv_pkg::TEXT_W-1:0]    text_reg, text_next;

    // ------------------------------------------------------------------
    // RAM ports and scan unit
    // ------------------------------------------------------------------
    logic                       kc_we;
    logic [IDX_W-1:0]           kc_waddr;
    logic [KC_W-1:0]            kc_wdata;
    logic [KC_W-1:0]            kc_rdata;

    logic                       dm_we;
    logic [IDX_W-1:0]           dm_waddr;
    logic [rkv_pkg::DATA_W-1:0] dm_wdata;
    logic [rkv_pkg::DATA_W-1:0] dm_rdata;

    rkv_pkg::scan_flags_t       scan_flags;
    logic [IDX_W-1:0]           hit_idx;
    logic [COUNT_BITS-1:0]      hit_count;
    logic [IDX_W-1:0]           free_idx;

    logic                       accept;
    logic                       out_free;
    logic                       out_load;
    logic [COUNT_BITS-1:0]      count_inc;

    // key in the high bits, count in the low bits
    rkv_ram #(
        .WIDTH (KC_W),
        .DEPTH (ENTRIES)
    ) u_kc_ram (
        .clk   (clk),
        .we    (kc_we),
        .waddr (kc_waddr),
        .wdata (kc_wdata),
        .raddr (issue_idx_reg),
        .rdata (kc_rdata)
    );

    // {value, text}; read address follows the matched slot
    rkv_ram #(
        .WIDTH (rkv_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (hit_idx),
        .rdata (dm_rdata)
    );

    rkv_scan #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .chk_vld   (chk_vld_reg),
        .chk_idx   (chk_idx_reg),
        .rd_key    (kc_rdata[KC_W-1:COUNT_BITS]),
        .rd_count  (kc_rdata[COUNT_BITS-1:0]),
        .req_key   (req_key_reg),
        .flags     (scan_flags),
        .hit_idx   (hit_idx),
        .hit_count (hit_count),
        .free_idx  (free_idx)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != rkv_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    // result slot is free this cycle, or its transaction leaves at this edge
    assign out_free  = !out_valid_reg || !out_stall;
    // saturating increment
    assign count_inc = (hit_count == '1) ? hit_count : hit_count + COUNT_BITS'(1);

    assign logging_enabled_next = cfg_wr_en ? cfg_wr_data : logging_enabled_reg;

    // ------------------------------------------------------------------
    // Scan sequencing and request capture
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_idx_next    = clr_idx_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        req_action_next = req_action_reg;
        req_key_next    = req_key_reg;
        req_value_next  = req_value_reg;
        req_text_next   = req_text_reg;
        chk_vld_next    = (state_reg == rkv_pkg::ST_SCAN) && !issue_done_reg;
        chk_idx_next    = issue_idx_reg;

        if (state_reg == rkv_pkg::ST_CLEAR)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
        end

        if (accept)
        begin
            issue_idx_next  = '0;
            issue_done_next = 1'b0;
            req_action_next = action;
            req_key_next    = KEY_BITS'(key);
            req_value_next  = value_in;
            req_text_next   = {text_high_in, text_low_in};
        end
        else if ((state_reg == rkv_pkg::ST_SCAN) && !issue_done_reg)
        begin
            if (issue_idx_reg == LAST_IDX)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + IDX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rkv_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = rkv_pkg::ST_IDLE;
                end
            end
            rkv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rkv_pkg::ST_SCAN;
                end
            end
            rkv_pkg::ST_SCAN:
            begin
                // last slot checked this cycle; flags settle at this edge
                if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next = rkv_pkg::ST_ACT;
                end
            end
            rkv_pkg::ST_ACT:
            begin
                if (out_free)
                begin
                    if ((req_action_reg == rkv_pkg::ACTION_GET) && scan_flags.hit)
                    begin
                        state_next = rkv_pkg::ST_GET;
                    end
                    else
                    begin
                        state_next = rkv_pkg::ST_IDLE;
                    end
                end
            end
            rkv_pkg::ST_GET:
            begin
                state_next = rkv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rkv_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: RAM writes and result load
    // ------------------------------------------------------------------
    always_comb
    begin
        kc_we       = 1'b0;
        kc_waddr    = hit_idx;
        kc_wdata    = {req_key_reg, hit_count};
        dm_we       = 1'b0;
        dm_waddr    = hit_idx;
        dm_wdata    = {req_value_reg, term_text(req_text_reg)};
        out_load    = 1'b0;
        status_next = rkv_pkg::STATUS_OK;
        value_next  = '0;
        text_next   = '0;

        unique case (state_reg)
            rkv_pkg::ST_CLEAR:
            begin
                kc_we    = 1'b1;
                kc_waddr = clr_idx_reg;
                kc_wdata = '0;
                dm_we    = 1'b1;
                dm_waddr = clr_idx_reg;
                dm_wdata = '0;
            end
            rkv_pkg::ST_ACT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    unique case (req_action_reg)
                        rkv_pkg::ACTION_ADD:
                        begin
                            if (scan_flags.hit)
                            begin
                                kc_we    = 1'b1;
                                kc_wdata = {req_key_reg, count_inc};
                            end
                            else if (scan_flags.free)
                            begin
                                kc_we    = 1'b1;
                                kc_waddr = free_idx;
                                kc_wdata = {req_key_reg, COUNT_BITS'(1)};
                            end
                            else
                            begin
                                status_next = rkv_pkg::STATUS_FULL;
                            end
                        end
                        rkv_pkg::ACTION_DEL:
                        begin
                            if (scan_flags.hit)
                            begin
                                kc_we    = 1'b1;
                                kc_wdata = {req_key_reg, hit_count - COUNT_BITS'(1)};
                            end
                        end
                        rkv_pkg::ACTION_LOG:
                        begin
                            if (logging_enabled_reg)
                            begin
                                if (scan_flags.hit)
                                begin
                                    dm_we = 1'b1;
                                end
                                else
                                begin
                                    status_next = rkv_pkg::STATUS_NOT_FOUND;
                                end
                            end
                        end
                        rkv_pkg::ACTION_GET:
                        begin
                            // a hit reads the data RAM and loads the result in ST_GET
                            if (scan_flags.hit)
                            begin
                                out_load = 1'b0;
                            end
                            else
                            begin
                                status_next = rkv_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            rkv_pkg::ST_GET:
            begin
                out_load   = 1'b1;
                value_next = dm_rdata[rkv_pkg::DATA_W-1:rkv_pkg::TEXT_W];
                text_next  = dm_rdata[rkv_pkg::TEXT_W-1:0];
            end
            default:
            begin
                kc_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= rkv_pkg::ST_CLEAR;
            logging_enabled_reg <= 1'b0;
            clr_idx_reg         <= '0;
            issue_idx_reg       <= '0;
            issue_done_reg      <= 1'b0;
            chk_vld_reg         <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            logging_enabled_reg <= logging_enabled_next;
            clr_idx_reg         <= clr_idx_next;
            issue_idx_reg       <= issue_idx_next;
            issue_done_reg      <= issue_done_next;
            chk_vld_reg         <= chk_vld_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        req_action_reg <= req_action_next;
        req_key_reg    <= req_key_next;
        req_value_reg  <= req_value_next;
        req_text_reg   <= req_text_next;
        if (out_load)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            text_reg   <= text_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign value_out     = value_reg;
    assign text_low_out  = text_reg[rkv_pkg::TEXT_LO_W-1:0];
    assign text_high_out = text_reg[rkv_pkg::TEXT_W-1:rkv_pkg::TEXT_LO_W];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a new result never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    // neither RAM is written while a scan reads the key RAM
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkv_pkg::ST_SCAN) |-> !kc_we && !dm_we)
        else $error("RAM write during scan");

    // a live match and a free slot cannot be the same slot
    a_hit_free_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_flags.hit && scan_flags.free) |-> (hit_idx != free_idx))
        else $error("hit and free slot coincide");

    // a matched slot is live
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        scan_flags.hit |-> (hit_count != '0))
        else $error("hit on a free slot");

    // after the get step of a hit, the result is valid
    a_get_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkv_pkg::ST_GET) |=> out_valid_reg)
        else $error("get result missing");

endmodule

// ===== test/refcounted_key_value_table_test.sv =====
// ----------------------------------------------------------------------------
// refcounted_key_value_table_test: self-checking bench for the key/value table
// Drives add, delete, log and get transactions with random gaps on both sides,
// mirrors the slot table in a local predictor and checks every response field.
// ----------------------------------------------------------------------------
module refcounted_key_value_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 128;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 8;
    localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
    localparam int IDX_W      = $clog2(ENTRIES);

    // one long receiver hold-off, early in the run, to back the table up
    localparam int PRESSURE_AT   = 60;
    localparam int PRESSURE_HOLD = 600;
    // cycles with no transaction and no config write before giving up
    localparam int WATCHDOG_LIMIT = 4 * (PRESSURE_HOLD + ENTRIES + 32);

    localparam logic [63:0] ONES64 = '1;
    localparam logic [55:0] ONES56 = '1;

    typedef struct packed {
        logic [1:0]                    action;
        logic [rkv_pkg::KEY_W-1:0]     key;
        logic [rkv_pkg::VALUE_W-1:0]   value;
        logic [rkv_pkg::TEXT_LO_W-1:0] text_lo;
        logic [rkv_pkg::TEXT_HI_W-1:0] text_hi;
    } request_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [rkv_pkg::VALUE_W-1:0]   value;
        logic [rkv_pkg::TEXT_LO_W-1:0] text_lo;
        logic [rkv_pkg::TEXT_HI_W-1:0] text_hi;
    } response_t;

    // a directed row: optional logging change first, then one transaction,
    // checked either against the typed response or against the predictor
    typedef struct packed {
        logic      cfg_write;
        logic      cfg_value;
        request_t  req;
        logic      typed;
        response_t resp;
    } script_row_t;

    localparam response_t RESP_OK   = '{rkv_pkg::STATUS_OK, 64'd0, 64'd0, 56'd0};
    localparam response_t RESP_MISS = '{rkv_pkg::STATUS_NOT_FOUND, 64'd0, 64'd0, 56'd0};
    localparam response_t RESP_ONES = '{rkv_pkg::STATUS_OK, ONES64, ONES64, ONES56};

    localparam int SCRIPT_LEN = 27;
    localparam script_row_t DIRECTED [SCRIPT_LEN] = '{
        // logging off (reset value)
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_MISS},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'h0000, ONES64, ONES64, ONES56}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_DEL, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_ADD, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_ADD, 16'hFFFF, ONES64, ONES64, ONES56}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'hFFFF, ONES64, ONES64, ONES56}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        // logging on
        '{1'b1, 1'b1, '{rkv_pkg::ACTION_LOG, 16'h0000, ONES64, ONES64, ONES56}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_ONES},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'h1234, ONES64, ONES64, ONES56}, 1'b1, RESP_MISS},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h1234, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_MISS},
        // text cut at byte 5, at byte 0, and inside the high word
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'hFFFF, 64'h0123_4567_89AB_CDEF,
                        64'h4847_0045_4443_4241, 56'h4F_4E4D_4C4B_4A49}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'h0000, 64'h8000_0000_0000_0001,
                        64'hFFFF_FFFF_FFFF_FF00, ONES56}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_LOG, 16'hFFFF, 64'h5555_AAAA_5555_AAAA,
                        64'h6867_6665_6463_6261, 56'hAA_BBCC_00DD_EEFF}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b0, '0},
        // reference counting: two users, two releases, then gone
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_ADD, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_DEL, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_DEL, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h0000, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_MISS},
        // reclaimed slot keeps the stale value and text
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_ADD, 16'h00FF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_GET, 16'h00FF, 64'd0, 64'd0, 56'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_DEL, 16'h00FF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b0, 1'b0, '{rkv_pkg::ACTION_DEL, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_OK},
        '{1'b1, 1'b0, '{rkv_pkg::ACTION_GET, 16'hFFFF, 64'd0, 64'd0, 56'd0}, 1'b1, RESP_MISS}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_wr_en    = 1'b0;
    logic                          cfg_wr_data  = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [1:0]                    action       = rkv_pkg::ACTION_ADD;
    logic [rkv_pkg::KEY_W-1:0]     key          = '0;
    logic [rkv_pkg::VALUE_W-1:0]   value_in     = '0;
    logic [rkv_pkg::TEXT_LO_W-1:0] text_low_in  = '0;
    logic [rkv_pkg::TEXT_HI_W-1:0] text_high_in = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [1:0]                    status;
    logic [rkv_pkg::VALUE_W-1:0]   value_out;
    logic [rkv_pkg::TEXT_LO_W-1:0] text_low_out;
    logic [rkv_pkg::TEXT_HI_W-1:0] text_high_out;

    refcounted_key_value_table #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .key           (key),
        .value_in      (value_in),
        .text_low_in   (text_low_in),
        .text_high_in  (text_high_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .value_out     (value_out),
        .text_low_out  (text_low_out),
        .text_high_out (text_high_out)
    );

    // ------------------------------------------------------------------
    // Mirror of the slot table, updated as each request transaction is taken
    // ------------------------------------------------------------------
    logic [rkv_pkg::KEY_W-1:0]     slot_key     [ENTRIES];
    logic [COUNT_BITS-1:0]         slot_uses    [ENTRIES];
    logic [rkv_pkg::VALUE_W-1:0]   slot_value   [ENTRIES];
    logic [rkv_pkg::TEXT_LO_W-1:0] slot_text_lo [ENTRIES];
    logic [rkv_pkg::TEXT_HI_W-1:0] slot_text_hi [ENTRIES];
    bit                            logging_on = 1'b0;

    response_t expected_responses[$];

    bit steady_flow = 1'b0;   // when set, neither side inserts gaps
    int failures          = 0;
    int requests_sent     = 0;
    int responses_checked = 0;
    int seen_ok           = 0;
    int seen_not_found    = 0;
    int seen_full         = 0;
    int logging_writes    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_key[i]     = '0;
            slot_uses[i]    = '0;
            slot_value[i]   = '0;
            slot_text_lo[i] = '0;
            slot_text_hi[i] = '0;
        end
    end

    // Apply one transaction to the mirror and return the response it earns.
    // Key match only counts on a live slot; a new key goes to the lowest free slot.
    function automatic response_t apply_to_table(input request_t req);
        response_t      resp;
        int             hit;
        int             vacant;
        logic [119:0]   txt;
        bit             ended;
        resp   = '0;
        hit    = -1;
        vacant = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (slot_uses[i] != 0 && slot_key[i] == req.key)
                hit = i;
            if (slot_uses[i] == 0)
                vacant = i;
        end
        resp.status = rkv_pkg::STATUS_OK;
        unique case (req.action)
            rkv_pkg::ACTION_ADD:
            begin
                if (hit >= 0)
                begin
                    // counts stick at their maximum
                    if (slot_uses[hit] != COUNT_MAX)
                        slot_uses[hit] = slot_uses[hit] + 1'b1;
                end
                else if (vacant >= 0)
                begin
                    slot_key[vacant]  = req.key;
                    slot_uses[vacant] = COUNT_BITS'(1);
                end
                else
                begin
                    resp.status = rkv_pkg::STATUS_FULL;
                end
            end
            rkv_pkg::ACTION_DEL:
            begin
                if (hit >= 0)
                    slot_uses[hit] = slot_uses[hit] - 1'b1;
            end
            rkv_pkg::ACTION_LOG:
            begin
                if (logging_on)
                begin
                    if (hit >= 0)
                    begin
                        // everything past the first NUL byte is stored as zero
                        txt   = {req.text_hi, req.text_lo};
                        ended = 1'b0;
                        for (int b = 0; b < rkv_pkg::TEXT_BYTES; b++)
                        begin
                            if (ended)
                                txt[8*b +: 8] = 8'h00;
                            else if (txt[8*b +: 8] == 8'h00)
                                ended = 1'b1;
                        end
                        slot_value[hit]   = req.value;
                        slot_text_lo[hit] = txt[63:0];
                        slot_text_hi[hit] = txt[119:64];
                    end
                    else
                    begin
                        resp.status = rkv_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                if (hit >= 0)
                begin
                    resp.value   = slot_value[hit];
                    resp.text_lo = slot_text_lo[hit];
                    resp.text_hi = slot_text_hi[hit];
                end
                else
                begin
                    resp.status = rkv_pkg::STATUS_NOT_FOUND;
                end
            end
        endcase
        return resp;
    endfunction

    // Half the texts draw NUL bytes often, the other half rarely.
    function automatic logic [119:0] random_text();
        logic [119:0] txt;
        int unsigned  zero_odds;
        zero_odds = ($urandom_range(1) == 0) ? 6 : 200;
        for (int b = 0; b < rkv_pkg::TEXT_BYTES; b++)
            txt[8*b +: 8] = ($urandom_range(zero_odds) == 0) ? 8'h00
                                                             : 8'($urandom_range(255, 1));
        return txt;
    endfunction

    function automatic request_t random_request(input logic [1:0] act,
                                                input logic [rkv_pkg::KEY_W-1:0] k);
        request_t req;
        req.action = act;
        req.key    = k;
        req.value  = {$urandom, $urandom};
        {req.text_hi, req.text_lo} = random_text();
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Request side: optional gap, present, hold until taken, then predict.
    // ------------------------------------------------------------------
    task automatic issue(input request_t req, input bit typed, input response_t typed_resp);
        int unsigned gap;
        response_t   predicted;
        gap = steady_flow ? 0 : $urandom_range(10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= req.action;
        key          <= req.key;
        value_in     <= req.value;
        text_low_in  <= req.text_lo;
        text_high_in <= req.text_hi;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        // taken at this edge; queue the expectation before any response can show up
        predicted = apply_to_table(req);
        expected_responses.push_back(typed ? typed_resp : predicted);
        requests_sent++;
    endtask

    task automatic wait_for_responses();
        in_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    // Only written with nothing in flight, so the mirror can switch at once.
    task automatic set_logging(input bit on);
        wait_for_responses();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        logging_on  = on;
        logging_writes++;
    endtask

    // Small key pool so adds, logs and gets keep landing on live slots;
    // about one key in ten is drawn from the whole range as noise.
    task automatic run_mixed(input int count);
        logic [rkv_pkg::KEY_W-1:0] key_pool [8];
        logic [rkv_pkg::KEY_W-1:0] k;
        logic [1:0]                act;
        int unsigned               pick;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            key_pool[i] = rkv_pkg::KEY_W'($urandom);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                act = rkv_pkg::ACTION_ADD;
            else if (pick < 55)
                act = rkv_pkg::ACTION_DEL;
            else if (pick < 80)
                act = rkv_pkg::ACTION_LOG;
            else
                act = rkv_pkg::ACTION_GET;
            k = ($urandom_range(9) == 0) ? rkv_pkg::KEY_W'($urandom)
                                         : key_pool[3'($urandom_range(7))];
            issue(random_request(act, k), 1'b0, '0);
        end
    endtask

    // Fill every slot and push past capacity, then release everything.
    task automatic run_fill();
        logic [rkv_pkg::KEY_W-1:0] k;
        repeat (ENTRIES + 12)
        begin
            k = rkv_pkg::KEY_W'($urandom);
            issue(random_request(rkv_pkg::ACTION_ADD, k), 1'b0, '0);
            if ($urandom_range(9) < 3)
                issue(random_request(rkv_pkg::ACTION_LOG, k), 1'b0, '0);
            if ($urandom_range(9) < 2)
                issue(random_request(rkv_pkg::ACTION_GET, k), 1'b0, '0);
            // an extra user on some slot; when full this must still succeed
            if ($urandom_range(9) == 0)
                issue(random_request(rkv_pkg::ACTION_ADD,
                                     slot_key[IDX_W'($urandom_range(ENTRIES - 1))]),
                      1'b0, '0);
        end
        for (int i = 0; i < ENTRIES; i++)
            while (slot_uses[i] != 0)
                issue(random_request(rkv_pkg::ACTION_DEL, slot_key[i]), 1'b0, '0);
    endtask

    // Drive one key's count into saturation; the extra adds must not count,
    // so COUNT_MAX deletes free the slot.
    task automatic run_saturation();
        logic [rkv_pkg::KEY_W-1:0] k;
        k = rkv_pkg::KEY_W'($urandom);
        repeat (COUNT_MAX + 2)
            issue(random_request(rkv_pkg::ACTION_ADD, k), 1'b0, '0);
        issue(random_request(rkv_pkg::ACTION_LOG, k), 1'b0, '0);
        issue(random_request(rkv_pkg::ACTION_GET, k), 1'b0, '0);
        repeat (COUNT_MAX)
            issue(random_request(rkv_pkg::ACTION_DEL, k), 1'b0, '0);
        issue(random_request(rkv_pkg::ACTION_GET, k), 1'b0, '0);
        issue(random_request(rkv_pkg::ACTION_DEL, k), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall per transaction, one long hold-off,
    // every field compared with the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : response_side
        int unsigned hold;
        response_t   exp_resp;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            hold = steady_flow ? 0 : $urandom_range(10);
            if (responses_checked == PRESSURE_AT)
                hold = PRESSURE_HOLD;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
            if (expected_responses.size() == 0)
            begin
                $error("response with nothing outstanding: status %0d", status);
                failures++;
            end
            else
            begin
                exp_resp = expected_responses.pop_front();
                if (status !== exp_resp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_resp.status, status);
                    failures++;
                end
                if (value_out !== exp_resp.value)
                begin
                    $error("value_out: expected %h, got %h", exp_resp.value, value_out);
                    failures++;
                end
                if (text_low_out !== exp_resp.text_lo)
                begin
                    $error("text_low_out: expected %h, got %h",
                           exp_resp.text_lo, text_low_out);
                    failures++;
                end
                if (text_high_out !== exp_resp.text_hi)
                begin
                    $error("text_high_out: expected %h, got %h",
                           exp_resp.text_hi, text_high_out);
                    failures++;
                end
            end
            responses_checked++;
            unique case (status)
                rkv_pkg::STATUS_OK:        seen_ok++;
                rkv_pkg::STATUS_NOT_FOUND: seen_not_found++;
                default:                   seen_full++;
            endcase
        end
    end

    // Watchdog: too long with no transaction on either side ends the run.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && in_stall === 1'b0)
                       || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!rst_n);

        // directed rows; the table is still being cleared when the first is offered
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            if (DIRECTED[r].cfg_write)
                set_logging(DIRECTED[r].cfg_value);
            issue(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].resp);
        end

        // random phases; the long receiver hold-off lands in the first one
        set_logging(1'b1);
        run_mixed(50);

        set_logging(1'b0);
        steady_flow = 1'b1;
        run_mixed(50);
        steady_flow = 1'b0;

        set_logging(1'b1);
        run_fill();

        set_logging(1'b1);
        run_saturation();

        set_logging(1'b0);
        run_mixed(30);

        set_logging(1'b1);
        run_mixed(50);

        wait_for_responses();
        // room for a stray extra response to show up
        repeat (ENTRIES + 8) @(posedge clk);

        $display("%0d requests, %0d responses: %0d ok, %0d not found, %0d table full",
                 requests_sent, responses_checked, seen_ok, seen_not_found, seen_full);
        $display("logging written %0d times; table filled past capacity, one count saturated",
                 logging_writes);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== refcounted_key_value_table.f =====
rtl/core/rkv_pkg.sv
rtl/core/rkv_ram.sv
rtl/core/rkv_scan.sv
rtl/core/refcounted_key_value_table.sv
test/refcounted_key_value_table_test.sv
